// ===== hdl/sdspi_pkg.sv =====
// Shared types, constants and codes for the SD card SPI-mode host engine.
package sdspi_pkg;

   localparam int BLOCK_BYTES = 512;

   // Request function codes
   localparam logic [1:0] FN_INIT  = 2'd0;
   localparam logic [1:0] FN_READ  = 2'd1;
   localparam logic [1:0] FN_WRITE = 2'd2;
   localparam logic [1:0] FN_BYTE  = 2'd3;

   // Engine phases
   localparam logic [3:0] P_IDLE  = 4'd0;
   localparam logic [3:0] P_PRE   = 4'd1;
   localparam logic [3:0] P_READY = 4'd2;
   localparam logic [3:0] P_CMD   = 4'd3;
   localparam logic [3:0] P_RESP  = 4'd4;
   localparam logic [3:0] P_DIS   = 4'd5;
   localparam logic [3:0] P_IFC   = 4'd6;
   localparam logic [3:0] P_OCR   = 4'd7;
   localparam logic [3:0] P_RTOK  = 4'd8;
   localparam logic [3:0] P_RDATA = 4'd9;
   localparam logic [3:0] P_RCRC  = 4'd10;
   localparam logic [3:0] P_WTOK  = 4'd11;
   localparam logic [3:0] P_WDATA = 4'd12;
   localparam logic [3:0] P_WCRC  = 4'd13;
   localparam logic [3:0] P_WRESP = 4'd14;
   localparam logic [3:0] P_WBUSY = 4'd15;

   // Command contexts (what to do with the response)
   localparam logic [3:0] C_RESET = 4'd0;
   localparam logic [3:0] C_IFC   = 4'd1;
   localparam logic [3:0] C_PR55  = 4'd2;
   localparam logic [3:0] C_PR41  = 4'd3;
   localparam logic [3:0] C_L55   = 4'd4;
   localparam logic [3:0] C_L41   = 4'd5;
   localparam logic [3:0] C_OCR   = 4'd6;
   localparam logic [3:0] C_BLEN  = 4'd7;
   localparam logic [3:0] C_READ  = 4'd8;
   localparam logic [3:0] C_WRITE = 4'd9;

   // Actions after chip-select release
   localparam logic [1:0] D_RESET  = 2'd0;
   localparam logic [1:0] D_FINISH = 2'd1;
   localparam logic [1:0] D_INITOK = 2'd2;

   // Status codes
   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_RESET    = 4'd1;
   localparam logic [3:0] ST_VOLTAGE  = 4'd2;
   localparam logic [3:0] ST_PATTERN  = 4'd3;
   localparam logic [3:0] ST_OPCOND   = 4'd4;
   localparam logic [3:0] ST_OCR      = 4'd5;
   localparam logic [3:0] ST_BLOCKLEN = 4'd6;
   localparam logic [3:0] ST_RDCMD    = 4'd7;
   localparam logic [3:0] ST_RDTOKEN  = 4'd8;
   localparam logic [3:0] ST_WRCMD    = 4'd9;
   localparam logic [3:0] ST_WRREJECT = 4'd10;
   localparam logic [3:0] ST_BUSY     = 4'd11;

   // CSR register indexes
   localparam logic [2:0] R_RD_TOKEN  = 3'd0;
   localparam logic [2:0] R_WR_BUSY   = 3'd1;
   localparam logic [2:0] R_RETRY     = 3'd2;
   localparam logic [2:0] R_READY     = 3'd3;
   localparam logic [2:0] R_RESP_POLL = 3'd4;

   localparam logic [17:0] RD_TOKEN_RST  = 18'd255000;
   localparam logic [17:0] WR_BUSY_RST   = 18'd250000;
   localparam logic [14:0] RETRY_RST     = 15'h7fff;
   localparam logic [16:0] READY_RST     = 17'd100000;
   localparam logic [3:0]  RESP_POLL_RST = 4'd8;

   localparam logic [7:0] TOKEN_START = 8'hFE;
   localparam logic [7:0] IDLE_BYTE   = 8'hFF;

   typedef struct packed {
      logic [17:0] rd_token;
      logic [17:0] wr_busy;
      logic [14:0] retry;
      logic [16:0] ready;
      logic [3:0]  resp_poll;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [9:0]  byte_count;
      logic [17:0] poll_count;
      logic [14:0] retry_count;
      logic [2:0]  card_type;
      logic        in_init;
      logic [47:0] frame;
      logic [7:0]  last_resp;
      logic [3:0]  ctx;
      logic [1:0]  dctx;
      logic [3:0]  pend;
      logic        cs;
   } state_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       exchange_wanted;
      logic       cs_active;
      logic       slow_clock;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       wr_taken;
      logic       done_res;
      logic [3:0] status;
      logic [1:0] card_kind;
   } rsp_type;

endpackage

// ===== hdl/sd_spi_host_protocol_engine.sv =====
// Top level of the SD card SPI-mode host protocol engine.
//
// Use: the req channel carries one word per step. func 0 starts card init,
// 1 a sector read, 2 a sector write (sector gives the block number), and 3
// reports the byte just exchanged on SPI (rx_byte; wr_data is sent when the
// engine asks for write data). Each accepted word yields exactly one rsp word:
// the next byte to send, whether another exchange is wanted, chip select,
// the slow-clock flag, read data, a write-data-taken flag, completion and status.
// The user sets limits over csr APB only while the engine is idle; not enforced.
//
// A word is registered at the input, its step is computed by one pass of
// combinational logic and the result is written into the output register
// when that register is empty or being read out. While rsp_stall is low
// the engine takes one word per cycle; the input register and the output
// register form a two-deep queue.
// When rsp_stall is high the output word holds and the input register keeps
// at most one more word before req_stall goes high.
// Reset clears the engine to idle, chip select inactive, and loads the
// default limits.
module sd_spi_host_protocol_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_sector,
   input  logic [7:0]  req_wr_data,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_exchange_wanted,
   output logic        rsp_cs_active,
   output logic        rsp_slow_clock,
   output logic [7:0]  rsp_rd_data,
   output logic        rsp_rd_valid,
   output logic        rsp_wr_taken,
   output logic        rsp_done_res,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_card_kind,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sdspi_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  func_ff;
   logic [31:0] sector_ff;
   logic [7:0]  wr_data_ff;
   logic [7:0]  rx_byte_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;
   state_type   st_ff, st_in;
   rsp_type     res;
   cfg_type     cfg_ff, cfg_in;
   logic        advance;
   logic        accept;
   logic        csr_wr;
   logic [2:0]  reg_idx;

   // Queue control
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Configuration registers
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            R_RD_TOKEN:  cfg_in.rd_token  = pwdata[17:0];
            R_WR_BUSY:   cfg_in.wr_busy   = pwdata[17:0];
            R_RETRY:     cfg_in.retry     = pwdata[14:0];
            R_READY:     cfg_in.ready     = pwdata[16:0];
            R_RESP_POLL: cfg_in.resp_poll = pwdata[3:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         R_RD_TOKEN:  prdata = {14'd0, cfg_ff.rd_token};
         R_WR_BUSY:   prdata = {14'd0, cfg_ff.wr_busy};
         R_RETRY:     prdata = {17'd0, cfg_ff.retry};
         R_READY:     prdata = {15'd0, cfg_ff.ready};
         R_RESP_POLL: prdata = {28'd0, cfg_ff.resp_poll};
         default:     prdata = '0;
      endcase
   end

   // Engine step
   sdspi_step u_step (
      .st      (st_ff),
      .cfg     (cfg_ff),
      .func    (func_ff),
      .sector  (sector_ff),
      .wr_data (wr_data_ff),
      .rx_byte (rx_byte_ff),
      .ns      (st_in),
      .res     (res)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '{RD_TOKEN_RST, WR_BUSY_RST, RETRY_RST, READY_RST, RESP_POLL_RST};
         st_ff        <= '{last_resp: IDLE_BYTE, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) st_ff <= st_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         sector_ff  <= req_sector;
         wr_data_ff <= req_wr_data;
         rx_byte_ff <= req_rx_byte;
      end
      if (advance) out_ff <= res;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_tx_byte         = out_ff.tx_byte;
   assign rsp_exchange_wanted = out_ff.exchange_wanted;
   assign rsp_cs_active       = out_ff.cs_active;
   assign rsp_slow_clock      = out_ff.slow_clock;
   assign rsp_rd_data         = out_ff.rd_data;
   assign rsp_rd_valid        = out_ff.rd_valid;
   assign rsp_wr_taken        = out_ff.wr_taken;
   assign rsp_done_res        = out_ff.done_res;
   assign rsp_status          = out_ff.status;
   assign rsp_card_kind       = out_ff.card_kind;

endmodule

// ===== hdl/sdspi_step.sv =====
// Next-state and result logic for one word of the SD SPI host engine.
module sdspi_step (
   input  sdspi_pkg::state_type st,
   input  sdspi_pkg::cfg_type   cfg,
   input  logic [1:0]           func,
   input  logic [31:0]          sector,
   input  logic [7:0]           wr_data,
   input  logic [7:0]           rx_byte,
   output sdspi_pkg::state_type ns,
   output sdspi_pkg::rsp_type   res
);
   import sdspi_pkg::*;

   logic        cmd_go;
   logic [5:0]  cmd_num;
   logic [31:0] cmd_arg;
   logic [7:0]  cmd_crc;
   logic [3:0]  cmd_ctx;
   logic        dis_go;
   logic [1:0]  dis_ctx;
   logic [3:0]  dis_st;
   logic        fin_go;
   logic [3:0]  fin_st;
   logic [17:0] lim_ready;
   logic [17:0] lim_resp;
   logic [17:0] lim_rtok;
   logic [17:0] lim_wbusy;
   logic [9:0]  bc_inc;
   logic [47:0] new_frame;

   // Zero limits act as one poll
   assign lim_ready = (cfg.ready == '0) ? 18'd1 : {1'b0, cfg.ready};
   assign lim_resp  = (cfg.resp_poll == '0) ? 18'd1 : {14'd0, cfg.resp_poll};
   assign lim_rtok  = (cfg.rd_token == '0) ? 18'd1 : cfg.rd_token;
   assign lim_wbusy = (cfg.wr_busy == '0) ? 18'd1 : cfg.wr_busy;
   assign bc_inc    = st.byte_count + 10'd1;

   function automatic logic [7:0] frame_byte(input logic [47:0] f, input logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0:    b = f[47:40];
         3'd1:    b = f[39:32];
         3'd2:    b = f[31:24];
         3'd3:    b = f[23:16];
         3'd4:    b = f[15:8];
         default: b = f[7:0];
      endcase
      return b;
   endfunction

   always_comb begin
      ns      = st;
      res     = '0;
      res.tx_byte = IDLE_BYTE;
      cmd_go  = 1'b0;
      cmd_num = '0;
      cmd_arg = '0;
      cmd_crc = IDLE_BYTE;
      cmd_ctx = C_RESET;
      dis_go  = 1'b0;
      dis_ctx = D_FINISH;
      dis_st  = ST_OK;
      fin_go  = 1'b0;
      fin_st  = ST_OK;

      // Main decision: request start or one engine step
      if (func == FN_INIT) begin
         ns.card_type  = '0;
         ns.in_init    = 1'b1;
         ns.cs         = 1'b0;
         ns.phase      = P_PRE;
         ns.byte_count = 10'd1;
         res.exchange_wanted = 1'b1;
      end else if (func == FN_READ || func == FN_WRITE) begin
         cmd_go  = 1'b1;
         cmd_num = (func == FN_READ) ? 6'd17 : 6'd24;
         cmd_arg = st.card_type[2] ? sector : {sector[22:0], 9'd0};
         cmd_ctx = (func == FN_READ) ? C_READ : C_WRITE;
      end else if (st.phase != P_IDLE) begin
         res.exchange_wanted = 1'b1;
         case (st.phase)
            P_PRE: begin
               if (st.byte_count < 10'd11) ns.byte_count = bc_inc;
               else begin
                  cmd_go = 1'b1; cmd_num = 6'd0; cmd_crc = 8'h95; cmd_ctx = C_RESET;
               end
            end
            P_READY: begin
               if (rx_byte == IDLE_BYTE || st.poll_count >= lim_ready) begin
                  ns.phase = P_CMD; ns.byte_count = '0;
                  res.tx_byte = frame_byte(st.frame, 3'd0);
               end else ns.poll_count = st.poll_count + 18'd1;
            end
            P_CMD: begin
               if (st.byte_count < 10'd5) begin
                  ns.byte_count = bc_inc;
                  res.tx_byte = frame_byte(st.frame, bc_inc[2:0]);
               end else begin
                  ns.phase = P_RESP; ns.poll_count = 18'd1;
               end
            end
            P_RESP: begin
               if (rx_byte != IDLE_BYTE || st.poll_count >= lim_resp) begin
                  ns.last_resp = rx_byte;
                  case (st.ctx)
                     C_RESET: begin
                        dis_go = 1'b1; dis_ctx = D_RESET; dis_st = ST_OK;
                     end
                     C_IFC: begin
                        if (!rx_byte[2]) begin
                           ns.phase = P_IFC; ns.byte_count = '0;
                        end else begin
                           cmd_go = 1'b1; cmd_num = 6'd55; cmd_ctx = C_PR55;
                        end
                     end
                     C_PR55: begin
                        cmd_go = 1'b1; cmd_num = 6'd41; cmd_ctx = C_PR41;
                     end
                     C_PR41: begin
                        if (!rx_byte[2]) ns.card_type[0] = 1'b1;
                        ns.retry_count = '0;
                        cmd_go = 1'b1;
                        if (ns.card_type[1:0] != 2'd0) begin
                           cmd_num = 6'd55; cmd_ctx = C_L55;
                        end else begin
                           cmd_num = 6'd1; cmd_ctx = C_L41;
                        end
                     end
                     C_L55: begin
                        cmd_go = 1'b1; cmd_num = 6'd41; cmd_ctx = C_L41;
                        cmd_arg = st.card_type[1] ? 32'h40000000 : 32'd0;
                     end
                     C_L41: begin
                        if (!rx_byte[0]) begin
                           cmd_go = 1'b1;
                           if (st.card_type[1]) begin
                              cmd_num = 6'd58; cmd_ctx = C_OCR;
                           end else begin
                              cmd_num = 6'd16; cmd_ctx = C_BLEN;
                              cmd_arg = 32'(BLOCK_BYTES);
                           end
                        end else if (st.retry_count == cfg.retry) begin
                           dis_go = 1'b1; dis_st = ST_OPCOND;
                        end else begin
                           ns.retry_count = st.retry_count + 15'd1;
                           cmd_go = 1'b1;
                           if (st.card_type[1:0] != 2'd0) begin
                              cmd_num = 6'd55; cmd_ctx = C_L55;
                           end else begin
                              cmd_num = 6'd1; cmd_ctx = C_L41;
                           end
                        end
                     end
                     C_OCR: begin
                        if (rx_byte != 8'd0) begin
                           dis_go = 1'b1; dis_st = ST_OCR;
                        end else begin
                           ns.phase = P_OCR; ns.byte_count = '0;
                        end
                     end
                     C_BLEN: begin
                        dis_go = 1'b1;
                        if (rx_byte != 8'd0) dis_st = ST_BLOCKLEN;
                        else dis_ctx = D_INITOK;
                     end
                     C_READ: begin
                        if (rx_byte != 8'd0) begin
                           fin_go = 1'b1; fin_st = ST_RDCMD;
                        end else begin
                           ns.phase = P_RTOK; ns.poll_count = 18'd1;
                        end
                     end
                     default: begin
                        if (rx_byte != 8'd0) begin
                           dis_go = 1'b1; dis_st = ST_WRCMD;
                        end else begin
                           ns.phase = P_WTOK; res.tx_byte = TOKEN_START;
                        end
                     end
                  endcase
               end else ns.poll_count = st.poll_count + 18'd1;
            end
            P_DIS: begin
               if (st.dctx == D_RESET) begin
                  if (st.last_resp != 8'd1) begin
                     fin_go = 1'b1; fin_st = ST_RESET;
                  end else begin
                     cmd_go = 1'b1; cmd_num = 6'd8; cmd_arg = 32'h1AA;
                     cmd_crc = 8'h87; cmd_ctx = C_IFC;
                  end
               end else begin
                  if (st.dctx == D_INITOK) ns.in_init = 1'b0;
                  fin_go = 1'b1; fin_st = st.pend;
               end
            end
            P_IFC: begin
               if (st.byte_count == 10'd2 && !rx_byte[0]) begin
                  fin_go = 1'b1; fin_st = ST_VOLTAGE;
               end else if (st.byte_count == 10'd3) begin
                  if (rx_byte != 8'hAA) begin
                     fin_go = 1'b1; fin_st = ST_PATTERN;
                  end else begin
                     ns.card_type[1] = 1'b1; ns.retry_count = '0;
                     cmd_go = 1'b1; cmd_num = 6'd55; cmd_ctx = C_L55;
                  end
               end else ns.byte_count = bc_inc;
            end
            P_OCR: begin
               if (st.byte_count == 10'd0 && rx_byte[6]) ns.card_type[2] = 1'b1;
               if (st.byte_count < 10'd3) ns.byte_count = bc_inc;
               else begin
                  cmd_go = 1'b1; cmd_num = 6'd16; cmd_ctx = C_BLEN;
                  cmd_arg = 32'(BLOCK_BYTES);
               end
            end
            P_RTOK: begin
               if (rx_byte == TOKEN_START) begin
                  ns.phase = P_RDATA; ns.byte_count = '0;
               end else if (st.poll_count >= lim_rtok) begin
                  fin_go = 1'b1; fin_st = ST_RDTOKEN;
               end else ns.poll_count = st.poll_count + 18'd1;
            end
            P_RDATA: begin
               res.rd_data  = rx_byte;
               res.rd_valid = 1'b1;
               if (bc_inc >= 10'(BLOCK_BYTES)) begin
                  ns.phase = P_RCRC; ns.byte_count = '0;
               end else ns.byte_count = bc_inc;
            end
            P_RCRC: begin
               if (st.byte_count == 10'd0) ns.byte_count = 10'd1;
               else dis_go = 1'b1;
            end
            P_WTOK: begin
               ns.phase = P_WDATA; ns.byte_count = 10'd1;
               res.wr_taken = 1'b1; res.tx_byte = wr_data;
            end
            P_WDATA: begin
               if (st.byte_count < 10'(BLOCK_BYTES)) begin
                  ns.byte_count = bc_inc;
                  res.wr_taken = 1'b1; res.tx_byte = wr_data;
               end else begin
                  ns.phase = P_WCRC; ns.byte_count = 10'd1;
               end
            end
            P_WCRC: begin
               if (st.byte_count == 10'd1) ns.byte_count = 10'd2;
               else ns.phase = P_WRESP;
            end
            P_WRESP: begin
               if (rx_byte[3:0] == 4'h5) begin
                  ns.phase = P_WBUSY; ns.poll_count = 18'd1;
               end else begin
                  dis_go = 1'b1; dis_st = ST_WRREJECT;
               end
            end
            P_WBUSY: begin
               if (rx_byte != 8'd0) dis_go = 1'b1;
               else if (st.poll_count >= lim_wbusy) begin
                  dis_go = 1'b1; dis_st = ST_BUSY;
               end else ns.poll_count = st.poll_count + 18'd1;
            end
            default: res.exchange_wanted = 1'b0;
         endcase
      end

      // Start a command frame
      new_frame = {2'b01, cmd_num, cmd_arg, cmd_crc};
      if (cmd_go) begin
         ns.frame = new_frame;
         ns.ctx   = cmd_ctx;
         ns.cs    = 1'b1;
         res.exchange_wanted = 1'b1;
         if (st.in_init) begin
            ns.phase = P_READY; ns.poll_count = 18'd1;
            res.tx_byte = IDLE_BYTE;
         end else begin
            ns.phase = P_CMD; ns.byte_count = '0;
            res.tx_byte = new_frame[47:40];
         end
      end

      // Release chip select, one trailing byte
      if (dis_go) begin
         ns.cs = 1'b0; ns.pend = dis_st; ns.dctx = dis_ctx; ns.phase = P_DIS;
         res.tx_byte = IDLE_BYTE;
      end

      // Request complete
      if (fin_go) begin
         ns.phase = P_IDLE;
         res.done_res = 1'b1;
         res.status = fin_st;
         res.tx_byte = IDLE_BYTE;
         res.exchange_wanted = 1'b0;
      end

      res.cs_active  = ns.cs;
      res.slow_clock = ns.in_init;
      if (ns.card_type[2]) res.card_kind = 2'd3;
      else if (ns.card_type[1]) res.card_kind = 2'd2;
      else if (ns.card_type[0]) res.card_kind = 2'd1;
      else res.card_kind = 2'd0;
   end

endmodule

// ===== hdl/sdspi_checker.sv =====
// Port-level assertions for the SD SPI host engine, bound to the top level.
module sdspi_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_exchange_wanted,
   input logic [7:0] rsp_rd_data,
   input logic       rsp_rd_valid,
   input logic       rsp_done_res,
   input logic [3:0] rsp_status
);

   // A stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("stalled rsp word changed");

   // Completion never asks for another exchange
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_exchange_wanted && rsp_tx_byte == 8'hFF)
      else $error("completion wants exchange");

   // Status only meaningful on completion
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == 4'd0)
      else $error("status without completion");

   // Read data is zero unless flagged
   a_rd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rd_valid |-> rsp_rd_data == 8'd0)
      else $error("stray read data");

endmodule

bind sd_spi_host_protocol_engine sdspi_checker u_sdspi_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_tx_byte         (rsp_tx_byte),
   .rsp_exchange_wanted (rsp_exchange_wanted),
   .rsp_rd_data         (rsp_rd_data),
   .rsp_rd_valid        (rsp_rd_valid),
   .rsp_done_res        (rsp_done_res),
   .rsp_status          (rsp_status)
);

// ===== sim/testbench.sv =====
// Testbench for the SD card SPI-mode host engine: card emulation, prediction and checking.
`timescale 1ns / 1ps

module testbench;
   import sdspi_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   // SD command indexes used in command frames
   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_SEND_OP   = 6'd1;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_BLOCK_LEN = 6'd16;
   localparam logic [5:0] CMD_READ_ONE  = 6'd17;
   localparam logic [5:0] CMD_WRITE_ONE = 6'd24;
   localparam logic [5:0] ACMD_SD_OP    = 6'd41;
   localparam logic [5:0] CMD_APP       = 6'd55;
   localparam logic [5:0] CMD_GET_OCR   = 6'd58;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FN_BYTE;
   logic [31:0] req_sector = '0;
   logic [7:0]  req_wr_data = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_exchange_wanted;
   logic        rsp_cs_active;
   logic        rsp_slow_clock;
   logic [7:0]  rsp_rd_data;
   logic        rsp_rd_valid;
   logic        rsp_wr_taken;
   logic        rsp_done_res;
   logic [3:0]  rsp_status;
   logic [1:0]  rsp_card_kind;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   sd_spi_host_protocol_engine uut (.*);

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned failures = 0;
   int unsigned cycles = 0;
   rsp_type     expected_words[$];

   // predicted engine state
   cfg_type     lims;
   logic [3:0]  e_phase;
   int unsigned e_bytes, e_polls;
   logic [14:0] e_retries;
   logic [2:0]  e_card;
   logic        e_init;
   logic [47:0] e_frame;
   logic [7:0]  e_last;
   logic [3:0]  e_ctx, e_pend;
   logic [1:0]  e_dctx;
   logic        e_cs;
   rsp_type     e_out;

   initial forever #5 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $error("%s: expected %0h, got %0h", name, exp, act);
         failures++;
      end
   endfunction

   // compare each word that the next edge will take
   always @(negedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("result word with no expectation waiting");
            failures++;
         end else begin
            exp = expected_words.pop_front();
            check_field("tx_byte", 32'(exp.tx_byte), 32'(rsp_tx_byte));
            check_field("exchange_wanted", 32'(exp.exchange_wanted),
                        32'(rsp_exchange_wanted));
            check_field("cs_active", 32'(exp.cs_active), 32'(rsp_cs_active));
            check_field("slow_clock", 32'(exp.slow_clock), 32'(rsp_slow_clock));
            check_field("rd_data", 32'(exp.rd_data), 32'(rsp_rd_data));
            check_field("rd_valid", 32'(exp.rd_valid), 32'(rsp_rd_valid));
            check_field("wr_taken", 32'(exp.wr_taken), 32'(rsp_wr_taken));
            check_field("done_res", 32'(exp.done_res), 32'(rsp_done_res));
            check_field("status", 32'(exp.status), 32'(rsp_status));
            check_field("card_kind", 32'(exp.card_kind), 32'(rsp_card_kind));
         end
      end
   end

   // ---------------- engine prediction ----------------
   function automatic int unsigned at_least_one(int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic void send_byte(logic [7:0] b);
      e_out.tx_byte = b;
      e_out.exchange_wanted = 1'b1;
   endfunction

   function automatic void complete(logic [3:0] st);
      e_phase = P_IDLE;
      e_out.done_res = 1'b1;
      e_out.status = st;
      e_out.tx_byte = IDLE_BYTE;
      e_out.exchange_wanted = 1'b0;
   endfunction

   function automatic void release_cs(logic [1:0] next, logic [3:0] st);
      e_cs = 1'b0;
      e_pend = st;
      e_dctx = next;
      e_phase = P_DIS;
      send_byte(IDLE_BYTE);
   endfunction

   function automatic logic [7:0] frame_byte(int unsigned k);
      return 8'(e_frame >> (40 - 8 * (k % 6)));
   endfunction

   function automatic void start_cmd(logic [5:0] cmd, logic [31:0] arg, logic [7:0] crc,
                                     logic [3:0] c);
      e_frame = {2'b01, cmd, arg, crc};
      e_ctx = c;
      e_cs = 1'b1;
      if (e_init) begin
         e_phase = P_READY;
         e_polls = 1;
         send_byte(IDLE_BYTE);
      end else begin
         e_phase = P_CMD;
         e_bytes = 0;
         send_byte(frame_byte(0));
      end
   endfunction

   function automatic void op_cond_cmd();
      if (e_card[1:0] != 0) start_cmd(CMD_APP, 0, 8'hFF, C_L55);
      else start_cmd(CMD_SEND_OP, 0, 8'hFF, C_L41);
   endfunction

   // act on a command response
   function automatic void handle_response();
      logic [7:0] r;
      r = e_last;
      case (e_ctx)
         C_RESET: release_cs(D_RESET, ST_OK);
         C_IFC: begin
            if (!r[2]) begin
               e_phase = P_IFC; e_bytes = 0; send_byte(IDLE_BYTE);
            end else start_cmd(CMD_APP, 0, 8'hFF, C_PR55);
         end
         C_PR55: start_cmd(ACMD_SD_OP, 0, 8'hFF, C_PR41);
         C_PR41: begin
            if (!r[2]) e_card[0] = 1'b1;
            e_retries = '0;
            op_cond_cmd();
         end
         C_L55: start_cmd(ACMD_SD_OP, e_card[1] ? 32'h4000_0000 : 32'h0, 8'hFF, C_L41);
         C_L41: begin
            if (!r[0]) begin
               if (e_card[1]) start_cmd(CMD_GET_OCR, 0, 8'hFF, C_OCR);
               else start_cmd(CMD_BLOCK_LEN, BLOCK_BYTES, 8'hFF, C_BLEN);
            end else if (e_retries == lims.retry) release_cs(D_FINISH, ST_OPCOND);
            else begin
               e_retries = e_retries + 1'b1;
               op_cond_cmd();
            end
         end
         C_OCR: begin
            if (r != 0) release_cs(D_FINISH, ST_OCR);
            else begin
               e_phase = P_OCR; e_bytes = 0; send_byte(IDLE_BYTE);
            end
         end
         C_BLEN: begin
            if (r != 0) release_cs(D_FINISH, ST_BLOCKLEN);
            else release_cs(D_INITOK, ST_OK);
         end
         C_READ: begin
            if (r != 0) complete(ST_RDCMD);
            else begin
               e_phase = P_RTOK; e_polls = 1; send_byte(IDLE_BYTE);
            end
         end
         default: begin
            if (r != 0) release_cs(D_FINISH, ST_WRCMD);
            else begin
               e_phase = P_WTOK; send_byte(TOKEN_START);
            end
         end
      endcase
   endfunction

   // advance on one exchanged byte
   function automatic void handle_byte(logic [7:0] rx, logic [7:0] wr);
      case (e_phase)
         P_PRE: begin
            if (e_bytes < 11) begin
               e_bytes++; send_byte(IDLE_BYTE);
            end else start_cmd(CMD_GO_IDLE, 0, 8'h95, C_RESET);
         end
         P_READY: begin
            if (rx == IDLE_BYTE || e_polls >= at_least_one(32'(lims.ready))) begin
               e_phase = P_CMD; e_bytes = 0; send_byte(frame_byte(0));
            end else begin
               e_polls++; send_byte(IDLE_BYTE);
            end
         end
         P_CMD: begin
            if (e_bytes < 5) begin
               e_bytes++; send_byte(frame_byte(e_bytes));
            end else begin
               e_phase = P_RESP; e_polls = 1; send_byte(IDLE_BYTE);
            end
         end
         P_RESP: begin
            if (rx != IDLE_BYTE || e_polls >= at_least_one(32'(lims.resp_poll))) begin
               e_last = rx;
               handle_response();
            end else begin
               e_polls++; send_byte(IDLE_BYTE);
            end
         end
         P_DIS: begin
            if (e_dctx == D_RESET) begin
               if (e_last != 8'h01) complete(ST_RESET);
               else start_cmd(CMD_IF_COND, 32'h1AA, 8'h87, C_IFC);
            end else begin
               if (e_dctx == D_INITOK) e_init = 1'b0;
               complete(e_pend);
            end
         end
         P_IFC: begin
            if (e_bytes == 2 && !rx[0]) complete(ST_VOLTAGE);
            else if (e_bytes == 3) begin
               if (rx != 8'hAA) complete(ST_PATTERN);
               else begin
                  e_card[1] = 1'b1; e_retries = '0; op_cond_cmd();
               end
            end else begin
               e_bytes++; send_byte(IDLE_BYTE);
            end
         end
         P_OCR: begin
            if (e_bytes == 0 && rx[6]) e_card[2] = 1'b1;
            if (e_bytes < 3) begin
               e_bytes++; send_byte(IDLE_BYTE);
            end else start_cmd(CMD_BLOCK_LEN, BLOCK_BYTES, 8'hFF, C_BLEN);
         end
         P_RTOK: begin
            if (rx == TOKEN_START) begin
               e_phase = P_RDATA; e_bytes = 0; send_byte(IDLE_BYTE);
            end else if (e_polls >= at_least_one(32'(lims.rd_token))) complete(ST_RDTOKEN);
            else begin
               e_polls++; send_byte(IDLE_BYTE);
            end
         end
         P_RDATA: begin
            e_out.rd_data = rx;
            e_out.rd_valid = 1'b1;
            e_bytes++;
            if (e_bytes >= BLOCK_BYTES) begin
               e_phase = P_RCRC; e_bytes = 0;
            end
            send_byte(IDLE_BYTE);
         end
         P_RCRC: begin
            if (e_bytes == 0) begin
               e_bytes = 1; send_byte(IDLE_BYTE);
            end else release_cs(D_FINISH, ST_OK);
         end
         P_WTOK: begin
            e_phase = P_WDATA; e_bytes = 1; e_out.wr_taken = 1'b1; send_byte(wr);
         end
         P_WDATA: begin
            if (e_bytes < BLOCK_BYTES) begin
               e_bytes++; e_out.wr_taken = 1'b1; send_byte(wr);
            end else begin
               e_phase = P_WCRC; e_bytes = 1; send_byte(IDLE_BYTE);
            end
         end
         P_WCRC: begin
            if (e_bytes == 1) begin
               e_bytes = 2; send_byte(IDLE_BYTE);
            end else begin
               e_phase = P_WRESP; send_byte(IDLE_BYTE);
            end
         end
         P_WRESP: begin
            if (rx[3:0] == 4'h5) begin
               e_phase = P_WBUSY; e_polls = 1; send_byte(IDLE_BYTE);
            end else release_cs(D_FINISH, ST_WRREJECT);
         end
         P_WBUSY: begin
            if (rx != 0) release_cs(D_FINISH, ST_OK);
            else if (e_polls >= at_least_one(32'(lims.wr_busy))) release_cs(D_FINISH, ST_BUSY);
            else begin
               e_polls++; send_byte(IDLE_BYTE);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type predict_exchange(logic [1:0] fn, logic [31:0] sector,
                                                logic [7:0] wr, logic [7:0] rx);
      e_out = '0;
      e_out.tx_byte = IDLE_BYTE;
      if (fn == FN_INIT) begin
         e_card = '0; e_init = 1'b1; e_cs = 1'b0;
         e_phase = P_PRE; e_bytes = 1; send_byte(IDLE_BYTE);
      end else if (fn == FN_READ || fn == FN_WRITE) begin
         if (fn == FN_READ)
            start_cmd(CMD_READ_ONE, e_card[2] ? sector : sector << 9, 8'hFF, C_READ);
         else
            start_cmd(CMD_WRITE_ONE, e_card[2] ? sector : sector << 9, 8'hFF, C_WRITE);
      end else if (e_phase != P_IDLE) begin
         handle_byte(rx, wr);
      end
      e_out.cs_active = e_cs;
      e_out.slow_clock = e_init;
      e_out.card_kind = e_card[2] ? 2'd3 : e_card[1] ? 2'd2 : e_card[0] ? 2'd1 : 2'd0;
      return e_out;
   endfunction

   // ---------------- card emulation ----------------
   function automatic logic [7:0] card_reply();
      logic [7:0] noise;
      int unsigned pct;
      noise = 8'($urandom_range(255));
      pct = $urandom_range(99);
      if ($urandom_range(99) < 6) return noise;
      case (e_phase)
         P_READY: return (pct < 85) ? IDLE_BYTE : noise;
         P_RESP: begin
            if (pct < 25) return IDLE_BYTE;
            case (e_ctx)
               C_RESET, C_PR55, C_L55: return 8'h01;
               C_IFC, C_PR41: return (pct < 70) ? 8'h01 : 8'h05;
               C_L41: return (pct < 65) ? 8'h00 : 8'h01;
               default: return 8'h00;
            endcase
         end
         P_IFC: return (e_bytes == 2) ? 8'h01 : (e_bytes == 3) ? 8'hAA : noise;
         P_OCR: return (e_bytes == 0) ? {pct[0], 1'b1, noise[5:0]} : noise;
         P_RTOK: return (pct < 30) ? TOKEN_START : IDLE_BYTE;
         P_WRESP: return {noise[7:4], 4'h5};
         P_WBUSY: return (pct < 35) ? (noise | 8'h01) : 8'h00;
         default: return noise;
      endcase
   endfunction

   // ---------------- drivers ----------------
   // Called at a rising edge; returns at the edge that takes the word.
   task automatic send_word(logic [1:0] fn, logic [31:0] sector, logic [7:0] wr,
                            logic [7:0] rx);
      rsp_type exp;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_sector <= sector;
      req_wr_data <= wr;
      req_rx_byte <= rx;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      exp = predict_exchange(fn, sector, wr, rx);
      expected_words.push_back(exp);
   endtask

   task automatic send_card_byte();
      send_word(FN_BYTE, $urandom, 8'($urandom_range(255)), card_reply());
   endtask

   // hold off the sender until every expected word has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         R_RD_TOKEN:  lims.rd_token = value[17:0];
         R_WR_BUSY:   lims.wr_busy = value[17:0];
         R_RETRY:     lims.retry = value[14:0];
         R_READY:     lims.ready = value[16:0];
         R_RESP_POLL: lims.resp_poll = value[3:0];
         default: ;
      endcase
   endtask

   task automatic set_limits(logic [17:0] rd, logic [17:0] wb, logic [14:0] rt,
                             logic [16:0] rdy, logic [3:0] rp);
      csr_write(R_RD_TOKEN, 32'(rd));
      csr_write(R_WR_BUSY, 32'(wb));
      csr_write(R_RETRY, 32'(rt));
      csr_write(R_READY, 32'(rdy));
      csr_write(R_RESP_POLL, 32'(rp));
   endtask

   // random requests and stray bytes; each request is followed by card bytes until it completes
   task automatic run_traffic(int unsigned words, int unsigned sidle, int unsigned rstall);
      int unsigned sent;
      int unsigned pick;
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      sent = 0;
      while (sent < words) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_word(FN_BYTE, $urandom, 8'($urandom_range(255)), 8'($urandom_range(255)));
            sent++;
         end else begin
            send_word(pick < 40 ? FN_INIT : pick < 70 ? FN_READ : FN_WRITE, $urandom,
                      8'($urandom_range(255)), 8'($urandom_range(255)));
            sent++;
         end
         while (e_phase != P_IDLE && sent < words) begin
            if ($urandom_range(999) < 2)
               send_word(2'($urandom_range(2)), $urandom, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            else send_card_byte();
            sent++;
         end
      end
      drain();
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      send_idle_pct = 16;
      recv_stall_pct = 58;
      send_word(FN_BYTE, 32'h0, 8'h00, 8'h00);          // byte while idle
      send_word(FN_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF);  // byte address wraps
      repeat (3) send_word(FN_BYTE, 32'h0, 8'hFF, 8'h00);
      send_word(FN_WRITE, 32'h0, 8'h00, 8'h00);         // abandons the read
      repeat (7) send_word(FN_BYTE, 32'hFFFF_FFFF, 8'hFF, 8'h00);
      send_word(FN_INIT, 32'hFFFF_FFFF, 8'h00, 8'hFF);
      repeat (11) send_word(FN_BYTE, 32'h0, 8'h00, 8'hFF);
      drain();
   endtask

   task automatic test_default_limits();
      run_traffic(80, 16, 58);
   endtask

   task automatic test_min_limits();
      set_limits(18'd1, 18'd1, 15'd1, 17'd1, 4'd1);
      run_traffic(80, 16, 58);
   endtask

   task automatic test_max_limits();
      set_limits(18'h3FFFF, 18'h3FFFF, 15'h7FFF, 17'h1FFFF, 4'd15);
      run_traffic(80, 58, 16);
   endtask

   task automatic test_mixed_limits();
      set_limits(18'($urandom_range(2, 40)), 18'($urandom_range(2, 40)),
                 15'($urandom_range(1, 6)), 17'($urandom_range(1, 20)),
                 4'($urandom_range(2, 14)));
      run_traffic(540, 0, 0);
   endtask

   initial begin
      lims = '{RD_TOKEN_RST, WR_BUSY_RST, RETRY_RST, READY_RST, RESP_POLL_RST};
      e_phase = P_IDLE; e_bytes = 0; e_polls = 0; e_retries = '0; e_card = '0;
      e_init = 1'b0; e_frame = '0; e_last = 8'hFF; e_ctx = '0; e_dctx = '0; e_pend = '0;
      e_cs = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_default_limits();
      test_min_limits();
      test_max_limits();
      test_mixed_limits();
      if (failures == 0 && expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
